### rtl/integrate_fire_neuron_array_assert.svh
// assertion macros used by the controller of the integrate-and-fire neuron array
`ifndef INTEGRATE_FIRE_NEURON_ARRAY_ASSERT_SVH
`define INTEGRATE_FIRE_NEURON_ARRAY_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IFN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ifn assertion failed");

// next-cycle implication, checked outside reset
`define IFN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ifn assertion failed");

`endif

### rtl/ifn_pkg.sv
// shared types and constants of the integrate-and-fire neuron array
`default_nettype none

package ifn_pkg;

  // item kinds
  localparam logic [1:0] KIND_INJECT  = 2'd0;
  localparam logic [1:0] KIND_SYNAPSE = 2'd1;
  localparam logic [1:0] KIND_UPDATE  = 2'd2;

  // configuration register indexes
  localparam logic REG_FIRE_THRESHOLD  = 1'b0;
  localparam logic REG_RESET_POTENTIAL = 1'b1;

  // register reset values, signed Q8.8
  localparam logic signed [15:0] FIRE_THRESHOLD_RESET  = 16'sd2560;
  localparam logic signed [15:0] RESET_POTENTIAL_RESET = 16'sd0;

  localparam logic signed [15:0] Q_MAX = 16'sh7fff;
  localparam logic signed [15:0] Q_MIN = 16'sh8000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // item accepted: latch fields, read the stores
    logic exec;     // compute, write back, load the result register
  } cmd_t;

endpackage

`default_nettype wire

### rtl/ifn_ctrl.sv
// controller state machine of the integrate-and-fire neuron array
`default_nettype none
`include "integrate_fire_neuron_array_assert.svh"

module ifn_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ifn_pkg::cmd_t     cmd
);
  import ifn_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_blocked;

  assign out_blocked = out_valid && out_stall;
  assign in_stall    = (state != S_IDLE);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.exec    = (state == S_EXEC) && !out_blocked;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_blocked) begin
          state_next     = S_IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `IFN_ASSERT_NEXT(a_accept_goes_exec, in_valid && !in_stall, state == S_EXEC)
  `IFN_ASSERT_NEXT(a_exec_loads_result, cmd.exec, out_valid && state == S_IDLE)
  `IFN_ASSERT_NEXT(a_blocked_exec_waits, state == S_EXEC && out_blocked, state == S_EXEC)

endmodule

`default_nettype wire

### rtl/ifn_datapath.sv
// neuron stores, configuration registers, saturating arithmetic and result register
`default_nettype none

module ifn_datapath #(
  parameter int NEURONS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ifn_pkg::cmd_t       cmd,
  input  wire logic [1:0]          kind,
  input  wire logic [7:0]          neuron_index,
  input  wire logic [7:0]          pre_index,
  input  wire logic signed [15:0]  value,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data,
  output logic                     spike,
  output logic signed [15:0]       potential,
  output logic                     saturated
);
  import ifn_pkg::*;

  // the 8-bit index never reaches beyond 256 neurons
  localparam int DEPTH = (NEURONS < 256) ? NEURONS : 256;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [16:0] sat_add(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
    logic [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      return {1'b1, (s[16] ? Q_MIN : Q_MAX)};
    end
    return {1'b0, s[15:0]};
  endfunction

  logic signed [15:0] fire_threshold;
  logic signed [15:0] reset_potential;

  logic signed [15:0] pot_mem [DEPTH];
  logic signed [15:0] cur_mem [DEPTH];
  logic signed [15:0] inj_mem [DEPTH];
  logic [DEPTH-1:0]   nrn_vld;
  logic [DEPTH-1:0]   spike_flag;

  // latched item and registered store reads
  logic [1:0]         kind_q;
  logic [AW-1:0]      addr_q;
  logic               in_range_q;
  logic               pre_fired_q;
  logic signed [15:0] value_q;
  logic signed [15:0] pot_rd;
  logic signed [15:0] cur_rd;
  logic signed [15:0] inj_rd;
  logic               nrn_vld_q;

  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      pre_addr;
  logic               pre_in_range;

  logic signed [15:0] pot_val;
  logic signed [15:0] cur_val;
  logic signed [15:0] inj_val;
  logic [16:0]        syn_sum;
  logic [16:0]        upd_sum;
  logic signed [15:0] upd_pre;
  logic               fires;
  logic signed [15:0] upd_pot;

  logic               wr_neuron;
  logic               wr_inject;
  logic               wr_synapse;
  logic               wr_update;

  assign rd_addr      = neuron_index[AW-1:0];
  assign pre_addr     = pre_index[AW-1:0];
  assign pre_in_range = {9'd0, pre_index} < 17'(NEURONS);

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_threshold  <= FIRE_THRESHOLD_RESET;
      reset_potential <= RESET_POTENTIAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRE_THRESHOLD:  fire_threshold  <= cfg_data;
        REG_RESET_POTENTIAL: reset_potential <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q      <= kind;
      addr_q      <= rd_addr;
      in_range_q  <= {9'd0, neuron_index} < 17'(NEURONS);
      pre_fired_q <= pre_in_range && spike_flag[pre_addr];
      value_q     <= value;
      pot_rd      <= pot_mem[rd_addr];
      cur_rd      <= cur_mem[rd_addr];
      inj_rd      <= inj_mem[rd_addr];
      nrn_vld_q   <= nrn_vld[rd_addr];
    end
  end

  // a neuron not touched since reset reads as zero in all three stores
  assign pot_val = nrn_vld_q ? pot_rd : 16'sd0;
  assign cur_val = nrn_vld_q ? cur_rd : 16'sd0;
  assign inj_val = nrn_vld_q ? inj_rd : 16'sd0;

  assign syn_sum = sat_add(cur_val, value_q);
  assign upd_sum = sat_add(pot_val, cur_val);
  assign upd_pre = upd_sum[15:0];
  assign fires   = upd_pre >= fire_threshold;
  assign upd_pot = fires ? reset_potential : upd_pre;

  assign wr_neuron  = cmd.exec && in_range_q;
  assign wr_inject  = wr_neuron && (kind_q == KIND_INJECT);
  assign wr_synapse = wr_neuron && (kind_q == KIND_SYNAPSE) && pre_fired_q;
  assign wr_update  = wr_neuron && (kind_q == KIND_UPDATE);

  // every write-back stores all three values so one valid bit covers them
  always_ff @(posedge clk) begin
    if (wr_neuron) begin
      inj_mem[addr_q] <= wr_inject ? value_q : inj_val;
      pot_mem[addr_q] <= wr_update ? upd_pot : pot_val;
      if (wr_synapse) begin
        cur_mem[addr_q] <= syn_sum[15:0];
      end else if (wr_update) begin
        cur_mem[addr_q] <= inj_val;
      end else begin
        cur_mem[addr_q] <= cur_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nrn_vld    <= '0;
      spike_flag <= '0;
    end else begin
      if (wr_neuron) begin
        nrn_vld[addr_q] <= 1'b1;
      end
      if (wr_update) begin
        spike_flag[addr_q] <= fires;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      spike     <= wr_update && fires;
      potential <= wr_update ? upd_pot : 16'sd0;
      saturated <= (wr_update && upd_sum[16]) || (wr_synapse && syn_sum[16]);
    end
  end

endmodule

`default_nettype wire

### rtl/integrate_fire_neuron_array.sv
// Array of linear integrate-and-fire neurons with saturating Q8.8 state.
// Input channel (in_valid / in_stall) carries one item: kind, neuron_index,
// pre_index and value. Kind inject writes a neuron's inject current, kind
// synapse adds value to the post neuron's current when the pre neuron
// spiked at its last update, kind update integrates and may fire.
// Output channel (out_valid / out_stall) returns exactly one result item
// per input item: spike, potential and saturated.
// At accept the neuron stores are read into registers; in the execute step
// the block does the saturating add and threshold compare, writes back and
// loads the result register. A new item is accepted only after the previous
// one has executed, set by the single read-modify-write of the neuron stores.
// The result register frees the input side: the next item is accepted while
// a result still waits; its execute cycle holds until that result is taken.
// Reset clears all neuron state at once through one valid bit per neuron
// (no clearing pass) and loads fire_threshold = 10.0 and reset_potential = 0.
// cfg_write / cfg_index / cfg_data write a register; write only
// while no item is in flight.
`default_nettype none

module integrate_fire_neuron_array #(
  parameter int NEURONS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          kind,
  input  wire logic [7:0]          neuron_index,
  input  wire logic [7:0]          pre_index,
  input  wire logic signed [15:0]  value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     spike,
  output logic signed [15:0]       potential,
  output logic                     saturated,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import ifn_pkg::*;

  cmd_t cmd;

  ifn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ifn_datapath #(
    .NEURONS (NEURONS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (kind),
    .neuron_index (neuron_index),
    .pre_index    (pre_index),
    .value        (value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .spike        (spike),
    .potential    (potential),
    .saturated    (saturated)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the integrate-and-fire neuron array
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ifn_pkg::*;

  localparam int NEURONS = 256;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int LONG_HOLD = 300;

  typedef struct {
    bit                  spike;
    logic signed [15:0]  potential;
    bit                  saturated;
  } neuron_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [7:0] neuron_index = '0;
  logic [7:0] pre_index = '0;
  logic signed [15:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic spike;
  logic signed [15:0] potential;
  logic saturated;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  integrate_fire_neuron_array #(.NEURONS(NEURONS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .neuron_index(neuron_index), .pre_index(pre_index), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .spike(spike), .potential(potential), .saturated(saturated),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // neuron state as the block should hold it
  logic signed [15:0] model_potential [NEURONS];
  logic signed [15:0] model_current [NEURONS];
  logic signed [15:0] model_inject [NEURONS];
  bit                 model_fired [NEURONS];
  logic signed [15:0] model_threshold;
  logic signed [15:0] model_reset_pot;

  neuron_result_t predicted_outputs [$];

  int mismatch_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int spikes_seen = 0;
  int clamps_seen = 0;
  int reg_writes = 0;

  // sender burst shaping
  bit gaps_on = 1'b1;
  int gap_max = 4;
  int burst_max = 8;
  int burst_left = 0;

  // receiver stall shaping
  stall_style_t stall_style = STALL_NONE;
  int stall_percent = 30;
  logic [15:0] stall_bits = 16'h0f0f;
  int hold_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic signed [15:0] sat_sum(input logic signed [15:0] a,
                                                 input logic signed [15:0] b,
                                                 output bit clipped);
    int s;
    s = int'(a) + int'(b);
    clipped = 1'b0;
    if (s > int'(Q_MAX)) begin
      clipped = 1'b1;
      return Q_MAX;
    end
    if (s < int'(Q_MIN)) begin
      clipped = 1'b1;
      return Q_MIN;
    end
    return s[15:0];
  endfunction

  // applies one item to the neuron state and returns the result it yields
  function automatic neuron_result_t apply_neuron_item(input logic [1:0] k,
                                                       input logic [7:0] post,
                                                       input logic [7:0] pre,
                                                       input logic signed [15:0] v);
    neuron_result_t r;
    logic signed [15:0] u;
    bit clipped;
    bit pre_fired;
    r.spike = 1'b0;
    r.potential = '0;
    clipped = 1'b0;
    if (int'(post) < NEURONS) begin
      case (k)
        KIND_INJECT: model_inject[post] = v;
        KIND_SYNAPSE: begin
          pre_fired = (int'(pre) < NEURONS) && model_fired[pre];
          if (pre_fired)
            model_current[post] = sat_sum(model_current[post], v, clipped);
        end
        KIND_UPDATE: begin
          u = sat_sum(model_potential[post], model_current[post], clipped);
          if (u >= model_threshold) begin
            model_fired[post] = 1'b1;
            u = model_reset_pot;
            r.spike = 1'b1;
          end else begin
            model_fired[post] = 1'b0;
          end
          model_potential[post] = u;
          model_current[post] = model_inject[post];
          r.potential = u;
        end
        default: ;
      endcase
    end
    r.saturated = clipped;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] k, input logic [7:0] post,
                           input logic [7:0] pre, input logic signed [15:0] v);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      if (gaps_on)
        gap = $urandom_range(0, gap_max);
    end
    // junk on the payload while no item is offered
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      kind = 2'($urandom);
      neuron_index = 8'($urandom);
      pre_index = 8'($urandom);
      value = 16'($urandom);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    neuron_index = post;
    pre_index = pre;
    value = v;
    do @(posedge clk); while (in_stall);
    predicted_outputs.push_back(apply_neuron_item(k, post, pre, v));
    items_sent++;
  endtask

  // stop offering items and wait until every result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (predicted_outputs.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_FIRE_THRESHOLD)
      model_threshold = data;
    else
      model_reset_pot = data;
    reg_writes++;
  endtask

  task automatic set_config(input logic signed [15:0] threshold,
                            input logic signed [15:0] reset_pot);
    wait_drained();
    write_reg(REG_FIRE_THRESHOLD, threshold);
    write_reg(REG_RESET_POTENTIAL, reset_pot);
  endtask

  // saturation both ways, spike gating, unused kind, top neuron index
  task automatic test_reset_and_edges();
    send_item(KIND_UPDATE, 8'd0, 8'd0, 16'sd0);
    send_item(KIND_INJECT, 8'd1, 8'd0, Q_MAX);
    send_item(KIND_UPDATE, 8'd1, 8'd0, 16'sd0);
    send_item(KIND_UPDATE, 8'd1, 8'd0, 16'sd0);
    send_item(KIND_SYNAPSE, 8'd2, 8'd1, Q_MIN);
    send_item(KIND_SYNAPSE, 8'd2, 8'd1, -16'sd1);
    send_item(KIND_SYNAPSE, 8'd2, 8'd0, 16'sd100);
    send_item(KIND_UPDATE, 8'd2, 8'd0, 16'sd0);
    send_item(KIND_UPDATE, 8'd2, 8'd0, 16'sd0);
    send_item(KIND_INJECT, 8'd255, 8'd255, Q_MIN);
    send_item(KIND_SYNAPSE, 8'd255, 8'd255, 16'sd5);
    send_item(KIND_UNUSED, 8'd1, 8'd1, Q_MAX);
    send_item(KIND_SYNAPSE, 8'd3, 8'd1, Q_MAX);
    send_item(KIND_SYNAPSE, 8'd3, 8'd1, Q_MAX);
    send_item(KIND_UPDATE, 8'd255, 8'd0, -16'sd1);
  endtask

  // threshold and reset potential at both ends of the range
  task automatic test_threshold_extremes();
    set_config(Q_MAX, Q_MIN);
    send_item(KIND_INJECT, 8'd4, 8'd0, Q_MAX);
    repeat (5) send_item(KIND_UPDATE, 8'd4, 8'd0, 16'sd0);
    set_config(Q_MIN, Q_MAX);
    send_item(KIND_UPDATE, 8'd5, 8'd0, 16'sd0);
    send_item(KIND_SYNAPSE, 8'd0, 8'd5, 16'sd1);
    send_item(KIND_UPDATE, 8'd0, 8'd0, 16'sd0);
    set_config(FIRE_THRESHOLD_RESET, RESET_POTENTIAL_RESET);
  endtask

  // mostly items on a small group of neurons so spikes gate synapses
  task automatic run_traffic(input int count, input int base, input int span);
    int pick;
    int w;
    logic [7:0] post;
    logic [7:0] pre;
    logic signed [15:0] v;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      post = 8'(base + $urandom_range(0, span - 1));
      pre = 8'(base + $urandom_range(0, span - 1));
      if ($urandom_range(0, 3) == 0) begin
        v = 16'($urandom);
      end else begin
        w = int'($urandom_range(0, 1023)) - 384;
        v = w[15:0];
      end
      if (pick < 15) begin
        w = int'($urandom_range(0, 1500));
        send_item(KIND_INJECT, post, pre, ($urandom_range(0, 4) == 0) ? v : w[15:0]);
      end else if (pick < 45) begin
        if ($urandom_range(0, 9) == 0)
          pre = 8'($urandom);
        send_item(KIND_SYNAPSE, post, pre, v);
      end else if (pick < 92) begin
        send_item(KIND_UPDATE, post, pre, v);
      end else begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    int span;
    int w;
    for (int phase = 0; phase < 6; phase++) begin
      w = int'($urandom_range(256, 4000));
      set_config(w[15:0], 16'($signed(int'($urandom_range(0, 767)) - 512)));
      stall_style = stall_style_t'(phase % 3);
      stall_percent = $urandom_range(10, 60);
      stall_bits = 16'($urandom);
      // keep at least one free slot in the rotating pattern
      stall_bits[0] = 1'b0;
      gaps_on = (phase != 2);
      gap_max = $urandom_range(1, 6);
      burst_max = $urandom_range(1, 12);
      span = (phase == 5) ? NEURONS : $urandom_range(2, 8);
      run_traffic(130, (span == NEURONS) ? 0 : $urandom_range(0, NEURONS - span), span);
    end
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    wait_drained();
    stall_style = STALL_NONE;
    gaps_on = 1'b0;
    hold_left = LONG_HOLD;
    run_traffic(40, 16, 4);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      case (stall_style)
        STALL_NONE:   out_stall = 1'b0;
        STALL_RANDOM: out_stall = ($urandom_range(0, 99) < stall_percent);
        default: begin
          stall_bits = {stall_bits[14:0], stall_bits[15]};
          out_stall = stall_bits[0];
        end
      endcase
    end
  end

  always @(posedge clk) begin
    neuron_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (spike) spikes_seen++;
      if (saturated) clamps_seen++;
      if (predicted_outputs.size() == 0) begin
        $error("result with no item outstanding");
        mismatch_count++;
      end else begin
        want = predicted_outputs.pop_front();
        if (spike !== want.spike) begin
          $error("spike: expected %0d, got %0d", want.spike, spike);
          mismatch_count++;
        end
        if (potential !== want.potential) begin
          $error("potential: expected %0d, got %0d", want.potential, potential);
          mismatch_count++;
        end
        if (saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, saturated);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int n = 0; n < NEURONS; n++) begin
      model_potential[n] = '0;
      model_current[n] = '0;
      model_inject[n] = '0;
      model_fired[n] = 1'b0;
    end
    model_threshold = FIRE_THRESHOLD_RESET;
    model_reset_pot = RESET_POTENTIAL_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_and_edges();
    test_threshold_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drained();

    $display("covered %0d items, %0d results, %0d spikes, %0d clamped sums, %0d reg writes",
             items_sent, results_seen, spikes_seen, clamps_seen, reg_writes);
    $display("stall modes, long receiver hold-off and threshold extremes exercised");
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
